@@ hw/rtl/vdp_host_port_and_vblank_core_macros.svh @@
// assertion macros used by the checker file
`ifndef VDP_HOST_PORT_AND_VBLANK_CORE_MACROS_SVH
`define VDP_HOST_PORT_AND_VBLANK_CORE_MACROS_SVH

// same-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define VHP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vhp check failed");

// next-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define VHP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vhp check failed");

`endif

@@ hw/rtl/vhp_pkg.sv @@
// types, constants and helper functions of the video processor host port
package vhp_pkg;

  localparam int VRAM_BYTES    = 16384;
  localparam int VRAM_AW       = $clog2(VRAM_BYTES);
  localparam int ADDR_W        = 14;
  localparam int ADDR_SPACE    = 1 << ADDR_W;
  localparam int MIRROR_STEPS  = (ADDR_SPACE + VRAM_BYTES - 1) / VRAM_BYTES - 1;
  localparam int LINE_W        = 9;
  localparam int VISIBLE_LINES = 192;
  localparam int NTSC_LINES    = 262;
  localparam int PAL_LINES     = 313;
  localparam int NUM_MODE_REGS = 8;
  localparam int IRQ_EN_BIT    = 5;
  localparam int CFG_AW        = 3;

  // mode register that holds the interrupt enable
  localparam logic [2:0] IRQ_MODE_REG = 3'd1;

  localparam logic [7:0] STATUS_VBLANK = 8'h80;
  localparam logic       CFG_PAL_IDX   = 1'b0;

  typedef enum logic [2:0] {
    KIND_RD_DATA   = 3'd0,
    KIND_RD_STATUS = 3'd1,
    KIND_WR_DATA   = 3'd2,
    KIND_WR_CTRL   = 3'd3,
    KIND_LINE_TICK = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CMD_READ_SETUP = 2'b00,
    CMD_ADDR_LO    = 2'b01,
    CMD_REG_WRITE  = 2'b10,
    CMD_ADDR_HI    = 2'b11
  } cmd_e;

  typedef struct packed {
    logic               rd;
    logic               wr;
    logic [VRAM_AW-1:0] addr;
    logic [7:0]         wdata;
  } vram_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
  } result_t;

  // keep masks of the mode registers: set bits are stored on a write
  function automatic logic [7:0] reg_mask(input logic [2:0] num);
    logic [7:0] m;
    case (num)
      3'd0:    m = 8'h03;
      3'd1:    m = 8'hfb;
      3'd2:    m = 8'h0f;
      3'd3:    m = 8'hff;
      3'd4:    m = 8'h07;
      3'd5:    m = 8'h7f;
      3'd6:    m = 8'h07;
      default: m = 8'hff;
    endcase
    return m;
  endfunction

  // fold the 14-bit address onto the memory, mirroring a smaller memory
  function automatic logic [VRAM_AW-1:0] mem_idx(input logic [ADDR_W-1:0] a);
    logic [ADDR_W:0] v;
    v = {1'b0, a};
    for (int i = 0; i < MIRROR_STEPS; i++) begin
      if (v >= (ADDR_W+1)'(VRAM_BYTES)) begin
        v = v - (ADDR_W+1)'(VRAM_BYTES);
      end
    end
    return v[VRAM_AW-1:0];
  endfunction

endpackage

@@ hw/rtl/vhp_vram.sv @@
// video memory with a registered read port and a clearing sweep after reset
module vhp_vram import vhp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  vram_req_t req_i,
  output logic [7:0] rdata_o,
  output logic      clr_busy_o
);

  logic [7:0]         mem [VRAM_BYTES];
  logic [7:0]         rdata_q;
  logic               clr_busy_q, clr_busy_d;
  logic [VRAM_AW-1:0] clr_addr_q, clr_addr_d;
  logic               we;
  logic [VRAM_AW-1:0] waddr;
  logic [7:0]         wdata;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + VRAM_AW'(1);
      if (clr_addr_q == VRAM_AW'(VRAM_BYTES - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign we    = clr_busy_q | req_i.wr;
  assign waddr = clr_busy_q ? clr_addr_q : req_i.addr;
  assign wdata = clr_busy_q ? 8'h00 : req_i.wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (req_i.rd) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o    = rdata_q;
  assign clr_busy_o = clr_busy_q;

endmodule

@@ hw/rtl/vhp_ctrl.sv @@
// item decoder: address, latch, control sequence, mode registers and line timing
module vhp_ctrl import vhp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [2:0] kind_i,
  input  logic [7:0] data_i,
  input  logic       pal_region_i,
  input  logic [7:0] rdata_i,
  output vram_req_t  req_o,
  output result_t    res_o,
  output logic       busy_o
);

  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [7:0]        latch_q, latch_d;
  logic              pend_q, pend_d;
  logic [7:0]        mode_q [NUM_MODE_REGS];
  logic [7:0]        mode_d [NUM_MODE_REGS];
  logic              vblank_q, vblank_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic              fill_q, fill_d;

  logic [ADDR_W-1:0] new_addr;
  logic [2:0]        reg_num;
  logic [7:0]        reg_val;
  logic [LINE_W-1:0] line_inc;
  logic [LINE_W-1:0] frame_len;
  logic              irq_en;
  cmd_e              cmd;

  assign new_addr  = {data_i[ADDR_W-9:0], latch_q};
  assign reg_num   = data_i[2:0];
  assign reg_val   = latch_q & reg_mask(reg_num);
  assign line_inc  = line_q + LINE_W'(1);
  assign frame_len = pal_region_i ? LINE_W'(PAL_LINES) : LINE_W'(NTSC_LINES);
  assign irq_en    = mode_q[IRQ_MODE_REG][IRQ_EN_BIT];
  assign cmd       = cmd_e'(data_i[7:6]);

  always_comb begin
    addr_d   = addr_q;
    latch_d  = latch_q;
    pend_d   = pend_q;
    mode_d   = mode_q;
    vblank_d = vblank_q;
    line_d   = line_q;
    fill_d   = 1'b0;
    req_o    = '0;
    res_o    = '0;

    // read-ahead data from the registered read port arrives in the cycle after the read was issued
    if (fill_q) begin
      latch_d = rdata_i;
    end

    if (accept_i) begin
      case (kind_i)
        KIND_RD_DATA: begin
          pend_d          = 1'b0;
          res_o.read_data = latch_q;
          req_o.rd        = 1'b1;
          req_o.addr      = mem_idx(addr_q);
          fill_d          = 1'b1;
          addr_d          = addr_q + ADDR_W'(1);
        end
        KIND_RD_STATUS: begin
          pend_d          = 1'b0;
          res_o.read_data = vblank_q ? STATUS_VBLANK : 8'h00;
          vblank_d        = 1'b0;
        end
        KIND_WR_DATA: begin
          pend_d      = 1'b0;
          req_o.wr    = 1'b1;
          req_o.addr  = mem_idx(addr_q);
          req_o.wdata = data_i;
          latch_d     = data_i;
          addr_d      = addr_q + ADDR_W'(1);
        end
        KIND_WR_CTRL: begin
          if (pend_q) begin
            pend_d = 1'b0;
            addr_d = new_addr;
            unique case (cmd)
              CMD_READ_SETUP: begin
                req_o.rd   = 1'b1;
                req_o.addr = mem_idx(new_addr);
                fill_d     = 1'b1;
                addr_d     = new_addr + ADDR_W'(1);
              end
              CMD_REG_WRITE: begin
                mode_d[reg_num] = reg_val;
                // enable switched on while the flag is already up
                res_o.irq = (reg_num == IRQ_MODE_REG) && vblank_q &&
                            reg_val[IRQ_EN_BIT] && !irq_en;
              end
              CMD_ADDR_LO, CMD_ADDR_HI: begin
              end
            endcase
          end else begin
            pend_d  = 1'b1;
            addr_d  = {addr_q[ADDR_W-1:8], data_i};
            latch_d = data_i;
          end
        end
        KIND_LINE_TICK: begin
          line_d = line_inc;
          if (line_inc == LINE_W'(VISIBLE_LINES)) begin
            vblank_d  = 1'b1;
            res_o.irq = irq_en && !vblank_q;
          end
          if (line_inc >= frame_len) begin
            line_d = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      latch_q  <= '0;
      pend_q   <= 1'b0;
      mode_q   <= '{default: '0};
      vblank_q <= 1'b0;
      line_q   <= '0;
      fill_q   <= 1'b0;
    end else begin
      addr_q   <= addr_d;
      latch_q  <= latch_d;
      pend_q   <= pend_d;
      mode_q   <= mode_d;
      vblank_q <= vblank_d;
      line_q   <= line_d;
      fill_q   <= fill_d;
    end
  end

  assign busy_o = fill_q;

endmodule

@@ hw/rtl/vhp_out_buf.sv @@
// two-entry result buffer: output register plus skid stage
module vhp_out_buf import vhp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t res_i,
  output logic    ready_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t res_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    advance;

  assign advance = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (advance) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = push_i;
        skid_d       = res_i;
      end else begin
        out_valid_d = push_i;
        out_d       = res_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

@@ hw/rtl/vdp_host_port_and_vblank_core.sv @@
// top level of the video processor host port with vertical blank timing
//
// input channel: in_valid_i / in_stall_o carry one item (kind_i, data_i) per
// transfer: data read, status read, data write, control write or line tick
// output channel: out_valid_o / out_stall_i carry one result per item
// (read_data_o, interrupt_pulse_o), in item order
// apb port: one register, pal_region at byte address 0 (0 ntsc, 1 pal frame)
// result: each result is registered on the accepting edge and is offered once
// the results ahead of it have left the output buffer
// throughput: one item per cycle while the output buffer has room, except that a
// data read and a read-setup control byte hold the input off: the read-ahead latch
// is filled from the video memory's registered read port, so the input stalls for it
// reset: all state clears; the video memory is then swept to zero, one byte a
// cycle, so in_stall_o stays high until the sweep has cleared every byte; apb writes
// are taken throughout
// receiver stall: a two-entry output buffer keeps taking results while one
// waits; once both entries hold a result the input stalls
module vdp_host_port_and_vblank_core import vhp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // item input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        kind_i,
  input  logic [7:0]        data_i,
  // result output
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        read_data_o,
  output logic              interrupt_pulse_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic      pal_q, pal_d;
  logic      cfg_wr;
  logic      accept;
  logic      clr_busy;
  logic      ctrl_busy;
  logic      buf_ready;
  logic [7:0] rdata;
  vram_req_t req;
  result_t   res;
  result_t   out_res;

  // configuration register, written on the access phase of an apb transfer
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    pal_d = pal_q;
    if (cfg_wr && (paddr[CFG_AW-1] == CFG_PAL_IDX)) begin
      pal_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_q <= 1'b0;
    end else begin
      pal_q <= pal_d;
    end
  end

  // addresses with the top address bit set read as zero, the rest read the region register
  assign prdata = (paddr[CFG_AW-1] == CFG_PAL_IDX) ? {31'b0, pal_q} : 32'b0;

  // hold items off during the clear sweep, a pending latch fill, or a full buffer
  assign in_stall_o = clr_busy || ctrl_busy || !buf_ready;
  assign accept     = in_valid_i && !in_stall_o;

  vhp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .kind_i       (kind_i),
    .data_i       (data_i),
    .pal_region_i (pal_q),
    .rdata_i      (rdata),
    .req_o        (req),
    .res_o        (res),
    .busy_o       (ctrl_busy)
  );

  vhp_vram u_vram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .rdata_o    (rdata),
    .clr_busy_o (clr_busy)
  );

  // every accepted item leaves exactly one result
  vhp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .res_i       (res),
    .ready_o     (buf_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign read_data_o       = out_res.read_data;
  assign interrupt_pulse_o = out_res.irq;

endmodule

@@ hw/rtl/vhp_checker.sv @@
// port-level checks of the host port, bound to the top level
`include "vdp_host_port_and_vblank_core_macros.svh"

module vhp_checker import vhp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [2:0]        kind_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [7:0]        read_data_o,
  input logic              interrupt_pulse_o
);

  logic in_xfer;
  logic out_held;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;

  // the clear sweep holds the input off right after reset
  `VHP_ASSERT_NOW(a_clear_after_reset, $rose(rst_ni), in_stall_o)

  // a data read waits for its read-ahead fill before the next transfer
  `VHP_ASSERT_NEXT(a_read_fill_stall, in_xfer && kind_i == KIND_RD_DATA, in_stall_o)

  // a stalled result stays offered
  `VHP_ASSERT_NEXT(a_out_hold, out_held, out_valid_o)

  // and keeps its payload
  `VHP_ASSERT_NEXT(a_out_stable, out_held, $stable(read_data_o) && $stable(interrupt_pulse_o))

endmodule

bind vdp_host_port_and_vblank_core vhp_checker u_vhp_checker (.*);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the video processor host port with vblank timing
module tb_top;
  import vhp_pkg::*;

  // one processor access or line tick as offered on the item channel
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } host_op_t;

  // item kinds that the port ignores
  localparam logic [2:0] KIND_SPARE_A = 3'd5;
  localparam logic [2:0] KIND_SPARE_B = 3'd6;
  localparam logic [2:0] KIND_SPARE_C = 3'd7;

  // mode register numbers used by the directed part
  localparam logic [2:0] MODE_REG_FIRST = 3'd0;
  localparam logic [2:0] IRQ_REG        = IRQ_MODE_REG;
  localparam logic [2:0] MODE_REG_LAST  = 3'd7;

  localparam logic [CFG_AW-1:0] PAL_REG_ADDR = '0;

  // bits kept on a mode register write, register 0 in the lowest byte
  localparam logic [8*NUM_MODE_REGS-1:0] REG_KEEP =
    {8'hff, 8'h07, 8'h7f, 8'h07, 8'hff, 8'h0f, 8'hfb, 8'h03};

  // length of the long receiver hold-off
  localparam int HOLD_CYCLES = 80;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  // item channel
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] kind     = '0;
  logic [7:0] data     = '0;

  // result channel
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] read_data;
  logic       irq_pulse;

  // configuration port
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  vdp_host_port_and_vblank_core uut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .kind_i            (kind),
    .data_i            (data),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .read_data_o       (read_data),
    .interrupt_pulse_o (irq_pulse),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // items waiting for the driver, results waiting for the block
  host_op_t host_ops[$];
  result_t  port_results[$];

  int ops_total    = 0;  // items queued so far, each gives one result
  int results_done = 0;  // results matched against an expectation
  int error_count  = 0;

  // idling, in cycles per hundred
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // long receiver hold-off, requested by bumping hold_req
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // set at the edge on which an item transfer took place
  logic in_took = 1'b0;

  // ---------------------------------------------------------------------------
  // predicted state of the port
  // ---------------------------------------------------------------------------
  logic [7:0]        vram_img [VRAM_BYTES];
  logic [ADDR_W-1:0] vaddr_img      = '0;
  logic [7:0]        latch_img      = '0;
  logic              second_pending = 1'b0;
  logic [7:0]        mode_img [NUM_MODE_REGS];
  logic              vblank_img     = 1'b0;
  logic [LINE_W-1:0] line_img       = '0;
  logic              pal_img        = 1'b0;

  // video memory and mode registers come out of reset cleared
  initial begin
    for (int i = 0; i < VRAM_BYTES; i++) vram_img[i] = 8'h00;
    for (int i = 0; i < NUM_MODE_REGS; i++) mode_img[i] = 8'h00;
  end

  // works out the result of one accepted item and moves the predicted state on
  task automatic predict_host_op(input logic [2:0] k, input logic [7:0] d,
                                 output result_t r);
    logic       irq_was;
    logic [2:0] num;
    int         frame;
    r = '0;
    case (k)
      KIND_RD_DATA: begin
        // hand back the read-ahead byte and fetch the next one
        second_pending = 1'b0;
        r.read_data    = latch_img;
        latch_img      = vram_img[vaddr_img % VRAM_BYTES];
        vaddr_img      = vaddr_img + 1'b1;
      end
      KIND_RD_STATUS: begin
        // vblank in bit 7, sprite bits read as zero; reading clears the flag
        second_pending = 1'b0;
        r.read_data    = vblank_img ? STATUS_VBLANK : 8'h00;
        vblank_img     = 1'b0;
      end
      KIND_WR_DATA: begin
        second_pending = 1'b0;
        vram_img[vaddr_img % VRAM_BYTES] = d;
        latch_img = d;
        vaddr_img = vaddr_img + 1'b1;
      end
      KIND_WR_CTRL: begin
        if (second_pending) begin
          second_pending = 1'b0;
          vaddr_img      = {d[5:0], latch_img};
          case (cmd_e'(d[7:6]))
            CMD_READ_SETUP: begin
              latch_img = vram_img[vaddr_img % VRAM_BYTES];
              vaddr_img = vaddr_img + 1'b1;
            end
            CMD_REG_WRITE: begin
              // the first byte goes to the register through its keep mask
              num           = d[2:0];
              irq_was       = mode_img[IRQ_REG][IRQ_EN_BIT];
              mode_img[num] = latch_img & REG_KEEP[8*num +: 8];
              if (num == IRQ_REG && vblank_img && mode_img[IRQ_REG][IRQ_EN_BIT] &&
                  !irq_was) begin
                r.irq = 1'b1;
              end
            end
            default: begin
              // address set only
            end
          endcase
        end else begin
          // first byte: low address and latch
          second_pending = 1'b1;
          vaddr_img      = {vaddr_img[ADDR_W-1:8], d};
          latch_img      = d;
        end
      end
      KIND_LINE_TICK: begin
        frame    = pal_img ? PAL_LINES : NTSC_LINES;
        line_img = line_img + 1'b1;
        if (line_img == VISIBLE_LINES) begin
          if (mode_img[IRQ_REG][IRQ_EN_BIT] && !vblank_img) r.irq = 1'b1;
          vblank_img = 1'b1;
        end
        // a line past the frame end, left by a region change, restarts the frame
        if (line_img >= frame) line_img = '0;
      end
      default: begin
        // spare kinds change nothing
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued items, changes at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_items
    host_op_t op;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (host_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        op = host_ops.pop_front();
        in_valid <= 1'b1;
        kind     <= op.kind;
        data     <= op.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: random idling, or a long hold-off counted here
  always @(negedge clk) begin : drive_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on each item transfer, checks each result transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    result_t predicted;
    result_t want;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_host_op(kind, data, predicted);
        port_results.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (port_results.size() == 0) begin
          $error("result with nothing expected: read_data %02h, interrupt_pulse %0b",
                 read_data, irq_pulse);
          error_count++;
        end else begin
          want = port_results.pop_front();
          results_done++;
          if (read_data !== want.read_data) begin
            $error("read_data: expected %02h, actual %02h", want.read_data, read_data);
            error_count++;
          end
          if (irq_pulse !== want.irq) begin
            $error("interrupt_pulse: expected %0b, actual %0b", want.irq, irq_pulse);
            error_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_op(input logic [2:0] k, input logic [7:0] d);
    host_op_t op;
    op.kind = k;
    op.data = d;
    host_ops.push_back(op);
    ops_total++;
  endfunction

  // waits until every queued item has given its result, returns after a rising edge
  task automatic wait_drained();
    do @(negedge clk); while (results_done != ops_total);
    @(posedge clk);
  endtask

  // region write over the apb port, only while the port is idle
  task automatic write_pal(input logic v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PAL_REG_ADDR;
    pwdata  <= {31'b0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pal_img = v;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // line ticks needed to bring the predicted scanline to a given line
  function automatic int ticks_to_line(input int target);
    int s;
    int n;
    int frame;
    frame = pal_img ? PAL_LINES : NTSC_LINES;
    s = line_img;
    n = 0;
    while (s != target && n < 1024) begin
      s = (s + 1) % (1 << LINE_W);
      if (s >= frame) s = 0;
      n++;
    end
    return n;
  endfunction

  // random processor traffic, mostly well-formed access sequences
  task automatic add_host_traffic(input int n_ops);
    int         counted;
    int         pick;
    int         burst;
    logic [7:0] lo;
    logic [5:0] hi;
    logic [2:0] num;
    cmd_e       cmd;
    counted = 0;
    while (counted < n_ops) begin
      pick  = $urandom_range(99);
      burst = $urandom_range(4, 1);
      // the low byte and the high bits each favour small values so reads meet earlier writes
      lo = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
      hi = $urandom_range(1) ? 6'd0 : 6'($urandom_range(63));
      if (pick < 30) begin
        queue_op(KIND_LINE_TICK, 8'($urandom));
        counted++;
      end else if (pick < 45) begin
        // address set, then a burst of data writes
        cmd = $urandom_range(1) ? CMD_ADDR_LO : CMD_ADDR_HI;
        queue_op(KIND_WR_CTRL, lo);
        queue_op(KIND_WR_CTRL, {cmd, hi});
        repeat (burst) queue_op(KIND_WR_DATA, 8'($urandom));
        counted += 2 + burst;
      end else if (pick < 60) begin
        // read setup, then a burst of data reads
        queue_op(KIND_WR_CTRL, lo);
        queue_op(KIND_WR_CTRL, {CMD_READ_SETUP, hi});
        repeat (burst) queue_op(KIND_RD_DATA, 8'($urandom));
        counted += 2 + burst;
      end else if (pick < 72) begin
        // register write, often the one holding the interrupt enable
        num = $urandom_range(1) ? IRQ_REG : 3'($urandom_range(7));
        queue_op(KIND_WR_CTRL, 8'($urandom));
        queue_op(KIND_WR_CTRL, {CMD_REG_WRITE, 3'($urandom), num});
        counted += 2;
      end else if (pick < 80) begin
        queue_op(KIND_RD_STATUS, 8'($urandom));
        counted++;
      end else if (pick < 88) begin
        queue_op($urandom_range(1) ? KIND_RD_DATA : KIND_WR_DATA, 8'($urandom));
        counted++;
      end else if (pick < 96) begin
        // lone control byte, breaks up the next sequence
        queue_op(KIND_WR_CTRL, 8'($urandom));
        counted++;
      end else begin
        queue_op(3'($urandom_range(KIND_SPARE_C, KIND_SPARE_A)), 8'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int n;
    send_idle_pct = 11;
    recv_idle_pct = 56;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // region register taken while the memory sweep still holds the input off
    write_pal(1'b0);

    // directed: status and data read straight after reset
    queue_op(KIND_RD_STATUS, 8'h00);
    queue_op(KIND_RD_DATA, 8'hff);
    // top address, write there and let the address wrap to zero
    queue_op(KIND_WR_CTRL, 8'hff);
    queue_op(KIND_WR_CTRL, 8'hff);
    queue_op(KIND_WR_DATA, 8'hff);
    queue_op(KIND_WR_DATA, 8'h00);
    // read setup at the top address, prefetch wraps the address
    queue_op(KIND_WR_CTRL, 8'hff);
    queue_op(KIND_WR_CTRL, {CMD_READ_SETUP, 6'h3f});
    queue_op(KIND_RD_DATA, 8'h00);
    queue_op(KIND_RD_DATA, 8'h00);
    // all-ones register writes through the keep masks
    queue_op(KIND_WR_CTRL, 8'hff);
    queue_op(KIND_WR_CTRL, {CMD_REG_WRITE, 3'b111, MODE_REG_FIRST});
    queue_op(KIND_WR_CTRL, 8'hff);
    queue_op(KIND_WR_CTRL, {CMD_REG_WRITE, 3'b000, IRQ_REG});
    queue_op(KIND_WR_CTRL, 8'hff);
    queue_op(KIND_WR_CTRL, {CMD_REG_WRITE, 3'b000, MODE_REG_LAST});
    // both plain address set codes
    queue_op(KIND_WR_CTRL, 8'h00);
    queue_op(KIND_WR_CTRL, {CMD_ADDR_LO, 6'h00});
    queue_op(KIND_WR_CTRL, 8'h5a);
    queue_op(KIND_WR_CTRL, {CMD_ADDR_HI, 6'h2a});
    // a status read between control bytes drops the pending first byte
    queue_op(KIND_WR_CTRL, 8'h12);
    queue_op(KIND_RD_STATUS, 8'hff);
    queue_op(KIND_WR_CTRL, 8'h34);
    queue_op(KIND_WR_DATA, 8'h55);
    queue_op(KIND_LINE_TICK, 8'hff);
    // spare kinds
    queue_op(KIND_SPARE_A, 8'haa);
    queue_op(KIND_SPARE_B, 8'h55);
    queue_op(KIND_SPARE_C, 8'hff);
    wait_drained();

    // ntsc frame, sender idles a little, receiver a lot
    add_host_traffic(80);
    wait_drained();
    // bring the scanline just short of vblank so the next phase crosses it
    n = ticks_to_line(VISIBLE_LINES - 6);
    repeat (n) queue_op(KIND_LINE_TICK, 8'($urandom));
    wait_drained();

    // idling the other way round
    send_idle_pct = 56;
    recv_idle_pct = 11;
    add_host_traffic(80);
    wait_drained();

    // pal frame, then park the scanline beyond the ntsc frame end
    write_pal(1'b1);
    add_host_traffic(50);
    wait_drained();
    n = ticks_to_line(PAL_LINES - 20);
    repeat (n) queue_op(KIND_LINE_TICK, 8'($urandom));
    wait_drained();

    // back to ntsc with the line past the end; no idling, one long hold-off
    write_pal(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req++;
    add_host_traffic(110);
    wait_drained();

    repeat (4) @(posedge clk);
    if (port_results.size() != 0) begin
      $error("%0d results never arrived", port_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit, well beyond the memory sweep plus the slowest item stream
  initial begin : run_limit
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
